>>> rtl/c8alu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8alu_pkg: shared types for the 8-bit processor ALU
// Operation codes, the registered operation beat and the result beat.
// ----------------------------------------------------------------------------
package c8alu_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_ADC   = 4'd1,
    OP_SUB   = 4'd2,
    OP_SBC   = 4'd3,
    OP_INC8  = 4'd4,
    OP_DEC8  = 4'd5,
    OP_DAA   = 4'd6,
    OP_ADD16 = 4'd7,
    OP_INC16 = 4'd8,
    OP_DEC16 = 4'd9
  } opcode_t;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    opcode_t     op;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [15:0] wide_a;
    logic [15:0] wide_b;
    flags_t      flags;
  } op_beat_t;

  typedef struct packed {
    logic [7:0]  result8;
    logic [15:0] result16;
    flags_t      flags;
  } res_beat_t;

  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [3:0] BCD_MAX      = 4'h9;

endpackage : c8alu_pkg
`default_nettype wire

>>> rtl/cpu8_alu_with_flags.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags: 8-bit processor ALU with Z, N, H and C flags
// Input register, one pass of flag and result logic, result register.
// ----------------------------------------------------------------------------
// Takes one operation beat per clock while the output side is not stalled,
// and returns one result beat for each, from the result register. The input
// register and the result register form a two-stage pipeline; a stalled
// result holds in the result register while a further beat waits in the
// input register. Opcodes 10 to 15 return zero results and pass the flags.
module cpu8_alu_with_flags
  import c8alu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [7:0]  in_acc,
  input  wire logic [7:0]  in_operand,
  input  wire logic [15:0] in_wide_a,
  input  wire logic [15:0] in_wide_b,
  input  wire logic        in_zero_in,
  input  wire logic        in_sub_in,
  input  wire logic        in_half_in,
  input  wire logic        in_carry_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_result8,
  output logic [15:0]      out_result16,
  output logic             out_zero_out,
  output logic             out_sub_out,
  output logic             out_half_out,
  output logic             out_carry_out
);

  logic      s1_valid_r;
  op_beat_t  s1_beat_r;
  logic      out_valid_r;
  res_beat_t res_r;
  res_beat_t res_nxt;
  logic      s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat_r.op      <= opcode_t'(in_opcode);
      s1_beat_r.acc     <= in_acc;
      s1_beat_r.operand <= in_operand;
      s1_beat_r.wide_a  <= in_wide_a;
      s1_beat_r.wide_b  <= in_wide_b;
      s1_beat_r.flags   <= '{z: in_zero_in, n: in_sub_in, h: in_half_in, c: in_carry_in};
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  // datapath
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum5;
  logic [8:0]  dif9;
  logic [4:0]  dif5;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic        daa_hi;
  logic        daa_lo;
  logic [7:0]  daa_add;
  logic [7:0]  daa_sub;

  always_comb begin
    cin   = (s1_beat_r.op == OP_ADC || s1_beat_r.op == OP_SBC) ? s1_beat_r.flags.c : 1'b0;
    sum9  = {1'b0, s1_beat_r.acc} + {1'b0, s1_beat_r.operand} + {8'd0, cin};
    sum5  = {1'b0, s1_beat_r.acc[3:0]} + {1'b0, s1_beat_r.operand[3:0]} + {4'd0, cin};
    dif9  = {1'b0, s1_beat_r.acc} - {1'b0, s1_beat_r.operand} - {8'd0, cin};
    dif5  = {1'b0, s1_beat_r.acc[3:0]} - {1'b0, s1_beat_r.operand[3:0]} - {4'd0, cin};
    sum17 = {1'b0, s1_beat_r.wide_a} + {1'b0, s1_beat_r.wide_b};
    sum13 = {1'b0, s1_beat_r.wide_a[11:0]} + {1'b0, s1_beat_r.wide_b[11:0]};
    daa_hi  = s1_beat_r.flags.c || (s1_beat_r.acc > DAA_HI_LIMIT);
    daa_lo  = s1_beat_r.flags.h || (s1_beat_r.acc[3:0] > BCD_MAX);
    daa_add = s1_beat_r.acc + (daa_hi ? DAA_HI_ADJ : 8'd0) + (daa_lo ? DAA_LO_ADJ : 8'd0);
    daa_sub = s1_beat_r.acc - (s1_beat_r.flags.c ? DAA_HI_ADJ : 8'd0)
                            - (s1_beat_r.flags.h ? DAA_LO_ADJ : 8'd0);

    res_nxt          = '0;
    res_nxt.flags    = s1_beat_r.flags;
    case (s1_beat_r.op)
      OP_ADD, OP_ADC: begin
        res_nxt.result8 = sum9[7:0];
        res_nxt.flags.n = 1'b0;
        res_nxt.flags.h = sum5[4];
        res_nxt.flags.c = sum9[8];
      end
      OP_SUB, OP_SBC: begin
        res_nxt.result8 = dif9[7:0];
        res_nxt.flags.n = 1'b1;
        res_nxt.flags.h = dif5[4];
        res_nxt.flags.c = dif9[8];
      end
      OP_INC8: begin
        res_nxt.result8 = s1_beat_r.acc + 8'd1;
        res_nxt.flags.n = 1'b0;
        res_nxt.flags.h = (s1_beat_r.acc[3:0] == 4'hF);
      end
      OP_DEC8: begin
        res_nxt.result8 = s1_beat_r.acc - 8'd1;
        res_nxt.flags.n = 1'b1;
        res_nxt.flags.h = (s1_beat_r.acc[3:0] == 4'h0);
      end
      OP_DAA: begin
        res_nxt.flags.h = 1'b0;
        if (!s1_beat_r.flags.n) begin
          res_nxt.result8 = daa_add;
          res_nxt.flags.c = daa_hi;
        end else begin
          res_nxt.result8 = daa_sub;
        end
      end
      OP_ADD16: begin
        res_nxt.result16 = sum17[15:0];
        res_nxt.flags.n  = 1'b0;
        res_nxt.flags.h  = sum13[12];
        res_nxt.flags.c  = sum17[16];
      end
      OP_INC16: res_nxt.result16 = s1_beat_r.wide_a + 16'd1;
      OP_DEC16: res_nxt.result16 = s1_beat_r.wide_a - 16'd1;
      default: ;
    endcase
    if (s1_beat_r.op inside {OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_INC8, OP_DEC8, OP_DAA}) begin
      res_nxt.flags.z = (res_nxt.result8 == 8'd0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result8   = res_r.result8;
  assign out_result16  = res_r.result16;
  assign out_zero_out  = res_r.flags.z;
  assign out_sub_out   = res_r.flags.n;
  assign out_half_out  = res_r.flags.h;
  assign out_carry_out = res_r.flags.c;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat did not reach result register");

  a_wide_step_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_beat_r.op == OP_INC16 || s1_beat_r.op == OP_DEC16)
    |=> res_r.flags == $past(s1_beat_r.flags) && res_r.result8 == 8'd0)
    else $error("16-bit step altered flags");

  a_sub_sets_n: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_beat_r.op == OP_SUB || s1_beat_r.op == OP_SBC ||
               s1_beat_r.op == OP_DEC8) |=> res_r.flags.n)
    else $error("subtract did not set N");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full");

endmodule : cpu8_alu_with_flags
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the cpu8_alu_with_flags arithmetic unit
// The bench sends directed corner cases and then random operations through
// the valid/ready handshake, with the sender idling and the receiver
// stalling at random. An in-bench flag model predicts each result beat.
// Results are compared field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module tb_top;
  import c8alu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // flag bits in z,n,h,c order
  localparam logic [3:0] FL_NONE = 4'b0000;
  localparam logic [3:0] FL_Z    = 4'b1000;
  localparam logic [3:0] FL_N    = 4'b0100;
  localparam logic [3:0] FL_H    = 4'b0010;
  localparam logic [3:0] FL_C    = 4'b0001;
  localparam logic [3:0] FL_ALL  = 4'b1111;

  typedef struct {
    op_beat_t  stim;
    res_beat_t want;
  } alu_expect_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_opcode;
  logic [7:0]  in_acc;
  logic [7:0]  in_operand;
  logic [15:0] in_wide_a;
  logic [15:0] in_wide_b;
  logic        in_zero_in;
  logic        in_sub_in;
  logic        in_half_in;
  logic        in_carry_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_result8;
  logic [15:0] out_result16;
  logic        out_zero_out;
  logic        out_sub_out;
  logic        out_half_out;
  logic        out_carry_out;

  alu_expect_t pending_results[$];
  int          fail_count    = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;

  cpu8_alu_with_flags dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_acc       (in_acc),
    .in_operand   (in_operand),
    .in_wide_a    (in_wide_a),
    .in_wide_b    (in_wide_b),
    .in_zero_in   (in_zero_in),
    .in_sub_in    (in_sub_in),
    .in_half_in   (in_half_in),
    .in_carry_in  (in_carry_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_result8  (out_result8),
    .out_result16 (out_result16),
    .out_zero_out (out_zero_out),
    .out_sub_out  (out_sub_out),
    .out_half_out (out_half_out),
    .out_carry_out(out_carry_out)
  );

  // low phase first so that no rising edge falls at time zero
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Flag and result model of one operation
  function automatic res_beat_t alu_predict(input op_beat_t b);
    res_beat_t   r;
    logic        cin;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [7:0]  t;
    r       = '0;
    r.flags = b.flags;
    cin     = 1'b0;
    case (b.op)
      OP_ADD, OP_ADC: begin
        if (b.op == OP_ADC) cin = b.flags.c;
        s9  = {1'b0, b.acc} + {1'b0, b.operand} + {8'd0, cin};
        s5  = {1'b0, b.acc[3:0]} + {1'b0, b.operand[3:0]} + {4'd0, cin};
        r.result8 = s9[7:0];
        r.flags.z = (s9[7:0] == 8'd0);
        r.flags.n = 1'b0;
        r.flags.h = s5[4];
        r.flags.c = s9[8];
      end
      OP_SUB, OP_SBC: begin
        if (b.op == OP_SBC) cin = b.flags.c;
        // bit 8 / bit 4 of the widened difference is the borrow
        s9  = {1'b0, b.acc} - {1'b0, b.operand} - {8'd0, cin};
        s5  = {1'b0, b.acc[3:0]} - {1'b0, b.operand[3:0]} - {4'd0, cin};
        r.result8 = s9[7:0];
        r.flags.z = (s9[7:0] == 8'd0);
        r.flags.n = 1'b1;
        r.flags.h = s5[4];
        r.flags.c = s9[8];
      end
      OP_INC8: begin
        r.result8 = b.acc + 8'd1;
        r.flags.z = (r.result8 == 8'd0);
        r.flags.n = 1'b0;
        r.flags.h = (b.acc[3:0] == 4'hF);
      end
      OP_DEC8: begin
        r.result8 = b.acc - 8'd1;
        r.flags.z = (r.result8 == 8'd0);
        r.flags.n = 1'b1;
        r.flags.h = (b.acc[3:0] == 4'h0);
      end
      OP_DAA: begin
        t = b.acc;
        if (!b.flags.n) begin
          if (b.flags.c || t > 8'h99) begin
            t         = t + 8'h60;
            r.flags.c = 1'b1;
          end
          if (b.flags.h || t[3:0] > 4'h9) t = t + 8'h06;
        end else begin
          if (b.flags.c) t = t - 8'h60;
          if (b.flags.h) t = t - 8'h06;
        end
        r.result8 = t;
        r.flags.z = (t == 8'd0);
        r.flags.h = 1'b0;
      end
      OP_ADD16: begin
        s17 = {1'b0, b.wide_a} + {1'b0, b.wide_b};
        s13 = {1'b0, b.wide_a[11:0]} + {1'b0, b.wide_b[11:0]};
        r.result16 = s17[15:0];
        r.flags.n  = 1'b0;
        r.flags.h  = s13[12];
        r.flags.c  = s17[16];
      end
      OP_INC16: r.result16 = b.wide_a + 16'd1;
      OP_DEC16: r.result16 = b.wide_a - 16'd1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic op_beat_t make_op(input logic [3:0] op, input logic [7:0] acc,
                                       input logic [7:0] operand, input logic [15:0] wa,
                                       input logic [15:0] wb, input logic [3:0] fl);
    op_beat_t b;
    b.op      = opcode_t'(op);
    b.acc     = acc;
    b.operand = operand;
    b.wide_a  = wa;
    b.wide_b  = wb;
    b.flags   = flags_t'(fl);
    return b;
  endfunction

  function automatic logic [7:0] pick8();
    logic [7:0] corner [8] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 7)];
    return 8'($urandom());
  endfunction

  function automatic logic [15:0] pick16();
    logic [15:0] corner [8] = '{16'h0000, 16'h0001, 16'h0FFF, 16'h1000,
                                16'h7FFF, 16'h8000, 16'hF000, 16'hFFFF};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 7)];
    return 16'($urandom());
  endfunction

  function automatic logic [7:0] pick_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  function automatic op_beat_t random_op();
    op_beat_t  b;
    op_beat_t  pre;
    res_beat_t r;
    logic [3:0] op;
    if ($urandom_range(0, 99) < 8) op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    else op = 4'($urandom_range(OP_DEC16, OP_ADD));
    b = make_op(op, pick8(), pick8(), pick16(), pick16(), 4'($urandom_range(0, 15)));
    // half the DAA beats follow a genuine BCD add or subtract
    if (op == OP_DAA && $urandom_range(0, 1) == 1) begin
      pre = make_op($urandom_range(0, 1) ? OP_ADC : OP_SBC, pick_bcd(), pick_bcd(),
                    16'd0, 16'd0, $urandom_range(0, 1) ? FL_C : FL_NONE);
      r       = alu_predict(pre);
      b.acc   = r.result8;
      b.flags = r.flags;
    end
    return b;
  endfunction

  task automatic send_op(input op_beat_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= b.op;
    in_acc      <= b.acc;
    in_operand  <= b.operand;
    in_wide_a   <= b.wide_a;
    in_wide_b   <= b.wide_b;
    in_zero_in  <= b.flags.z;
    in_sub_in   <= b.flags.n;
    in_half_in  <= b.flags.h;
    in_carry_in <= b.flags.c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  task automatic run_random(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) send_op(random_op());
  endtask

  task automatic test_arith_corners();
    send_op(make_op(OP_ADD, 8'hFF, 8'h01, 16'h0000, 16'h0000, FL_NONE));
    send_op(make_op(OP_ADD, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, FL_ALL));
    send_op(make_op(OP_ADD, 8'h0F, 8'h01, 16'h0000, 16'h0000, FL_Z));
    send_op(make_op(OP_ADC, 8'hFF, 8'h00, 16'h0000, 16'h0000, FL_C));
    send_op(make_op(OP_ADC, 8'h7F, 8'h80, 16'h0000, 16'h0000, FL_C | FL_N));
    send_op(make_op(OP_SUB, 8'h00, 8'h01, 16'h0000, 16'h0000, FL_NONE));
    send_op(make_op(OP_SUB, 8'h42, 8'h42, 16'h0000, 16'h0000, FL_C));
    send_op(make_op(OP_SBC, 8'h10, 8'h0F, 16'h0000, 16'h0000, FL_C));
    send_op(make_op(OP_SBC, 8'hFF, 8'hFF, 16'h0000, 16'h0000, FL_C | FL_Z));
    send_op(make_op(OP_INC8, 8'hFF, 8'h00, 16'h0000, 16'h0000, FL_C));
    send_op(make_op(OP_INC8, 8'h0F, 8'h00, 16'h0000, 16'h0000, FL_Z | FL_N));
    send_op(make_op(OP_DEC8, 8'h01, 8'h00, 16'h0000, 16'h0000, FL_H));
    send_op(make_op(OP_DEC8, 8'h00, 8'hFF, 16'h0000, 16'h0000, FL_C));
  endtask

  task automatic test_daa_cases();
    send_op(make_op(OP_DAA, 8'h9A, 8'h00, 16'h0000, 16'h0000, FL_NONE));
    send_op(make_op(OP_DAA, 8'h0A, 8'h00, 16'h0000, 16'h0000, FL_Z));
    send_op(make_op(OP_DAA, 8'h00, 8'h00, 16'h0000, 16'h0000, FL_C | FL_H));
    send_op(make_op(OP_DAA, 8'h00, 8'h00, 16'h0000, 16'h0000, FL_N | FL_C | FL_H));
    send_op(make_op(OP_DAA, 8'h99, 8'h00, 16'h0000, 16'h0000, FL_NONE));
    send_op(make_op(OP_DAA, 8'h66, 8'h00, 16'h0000, 16'h0000, FL_N | FL_H));
  endtask

  task automatic test_wide_ops();
    send_op(make_op(OP_ADD16, 8'h00, 8'h00, 16'hFFFF, 16'h0001, FL_Z));
    send_op(make_op(OP_ADD16, 8'hFF, 8'hFF, 16'h0FFF, 16'h0001, FL_N));
    send_op(make_op(OP_INC16, 8'h00, 8'h00, 16'hFFFF, 16'h1234, FL_ALL));
    send_op(make_op(OP_DEC16, 8'h00, 8'h00, 16'h0000, 16'h0000, FL_N | FL_H));
  endtask

  task automatic test_unused_opcodes();
    send_op(make_op(OP_UNUSED_LO, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, FL_ALL));
    send_op(make_op(OP_UNUSED_HI, 8'h5A, 8'hA5, 16'h1234, 16'hFEDC, FL_Z | FL_H));
  endtask

  task automatic test_full_rate();
    run_random(290, 0, 0);
  endtask

  task automatic test_sparse_sender();
    run_random(280, 85, 0);
  endtask

  task automatic test_slow_receiver();
    run_random(290, 0, 85);
  endtask

  task automatic test_both_idle();
    run_random(290, 29, 29);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : capture_ops
    op_beat_t s;
    if (rst_n && in_valid && in_ready) begin
      s = make_op(in_opcode, in_acc, in_operand, in_wide_a, in_wide_b,
                  {in_zero_in, in_sub_in, in_half_in, in_carry_in});
      pending_results.push_back('{stim: s, want: alu_predict(s)});
    end
  end

  always @(posedge clk) begin : check_results
    alu_expect_t e;
    res_beat_t   got;
    if (rst_n && out_valid && out_ready) begin
      got.result8  = out_result8;
      got.result16 = out_result16;
      got.flags    = {out_zero_out, out_sub_out, out_half_out, out_carry_out};
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result beat with nothing pending: r8 %h r16 %h znhc %b",
                                 got.result8, got.result16, got.flags));
      end else begin
        e = pending_results.pop_front();
        if (got.result8 !== e.want.result8 || got.result16 !== e.want.result16 ||
            got.flags.z !== e.want.flags.z || got.flags.n !== e.want.flags.n ||
            got.flags.h !== e.want.flags.h || got.flags.c !== e.want.flags.c) begin
          report_failure($sformatf(
            "op %0d acc %h opd %h wa %h wb %h znhc %b: want %h %h %b, got %h %h %b",
            e.stim.op, e.stim.acc, e.stim.operand, e.stim.wide_a, e.stim.wide_b,
            e.stim.flags, e.want.result8, e.want.result16, e.want.flags,
            got.result8, got.result16, got.flags));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** cpu8_alu_with_flags: FAILED **");
    $finish;
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_ADD;
    in_acc      <= '0;
    in_operand  <= '0;
    in_wide_a   <= '0;
    in_wide_b   <= '0;
    in_zero_in  <= 1'b0;
    in_sub_in   <= 1'b0;
    in_half_in  <= 1'b0;
    in_carry_in <= 1'b0;
    out_ready   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_arith_corners();
    test_daa_cases();
    test_wide_ops();
    test_unused_opcodes();
    test_full_rate();
    test_sparse_sender();
    test_slow_receiver();
    test_both_idle();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** cpu8_alu_with_flags: PASSED **");
    end else begin
      $display("** cpu8_alu_with_flags: FAILED **");
    end
    $finish;
  end

endmodule
